[rtl/core/crc32_remainder_byte_patch_unit_defines.svh]
// assertion macros for the crc32 remainder byte patch unit
`ifndef CRC32_REMAINDER_BYTE_PATCH_UNIT_DEFINES_SVH
`define CRC32_REMAINDER_BYTE_PATCH_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define CRBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CRBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/crbp_pkg.sv]
// shared types, constants and polynomial arithmetic for the crc32 byte patch unit
package crbp_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned POS_W           = 13;
   localparam int unsigned REM_W           = 32;
   localparam int unsigned WIDE_W          = REM_W + BYTE_W;
   localparam int unsigned MAX_LEN_DEFAULT = 4096;

   localparam logic [REM_W:0] CRC_POLY = 33'h1_04C1_1DB7;

   typedef enum logic [2:0] {
      ST_FILL  = 3'b001,
      ST_IDLE  = 3'b010,
      ST_PATCH = 3'b100
   } state_type;

   // reduce a degree < 40 polynomial modulo the crc polynomial
   function automatic logic [REM_W-1:0] crbp_reduce(input logic [WIDE_W-1:0] value);
      logic [WIDE_W-1:0] r;
      r = value;
      for (int j = BYTE_W; j >= 0; j--) begin
         if (r[j+REM_W]) begin
            r = r ^ (WIDE_W'(CRC_POLY) << j);
         end
      end
      return r[REM_W-1:0];
   endfunction

   // carryless product of a byte and a 32-bit remainder
   function automatic logic [WIDE_W-1:0] crbp_clmul(input logic [BYTE_W-1:0] a,
                                                    input logic [REM_W-1:0]  b);
      logic [WIDE_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (a[i]) begin
            acc = acc ^ (WIDE_W'(b) << i);
         end
      end
      return acc;
   endfunction

endpackage

[rtl/core/crc32_remainder_byte_patch_unit.sv]
// crc32 remainder with byte load and in-place byte patch, two memories
// a load result is registered on acceptance, a patch result after the patch stage
// throughput: one load word per cycle while the output is not blocked; a patch word
//    holds the input in the patch stage, for the registered read of both memories
// reset: after reset the power memory is filled with x^(8k) mod p, one entry per cycle;
//    no word is accepted until it is full; remainder and length clear at once
module crc32_remainder_byte_patch_unit #(
   parameter int unsigned MAX_LEN = crbp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [crbp_pkg::BYTE_W-1:0] req_byte_value,
   input  logic [crbp_pkg::POS_W-1:0]  req_position,
   input  logic                        req_first,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [crbp_pkg::REM_W-1:0]  rsp_remainder,
   output logic                        rsp_position_error
);
   import crbp_pkg::*;

   `include "crc32_remainder_byte_patch_unit_defines.svh"

   // address width of the two memories, length counter holds MAX_LEN itself
   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
   localparam int unsigned CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

   // message bytes, unwritten entries are never read by a legal patch
   logic [BYTE_W-1:0] msg_mem [MAX_LEN];
   // x^(8k) mod p, written by the fill pass after reset
   logic [REM_W-1:0]  pow_mem [MAX_LEN];

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   // fill pass
   logic [ADDR_W-1:0] fill_idx_ff, fill_idx_in;
   logic [REM_W-1:0]  fill_pow_ff, fill_pow_in;

   // patch stage
   logic              pat_err_ff, pat_err_in;
   logic [BYTE_W-1:0] pat_byte_ff, pat_byte_in;
   logic [ADDR_W-1:0] pat_idx_ff, pat_idx_in;
   logic [BYTE_W-1:0] msg_rd_ff;
   logic [REM_W-1:0]  pow_rd_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [REM_W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              out_blocked;
   logic              req_accept;
   logic              load_accept;
   logic              patch_accept;
   logic              patch_fire;
   logic [LEN_W-1:0]  eff_len;
   logic [REM_W-1:0]  eff_rem;
   logic              room;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  len_ext;
   logic [CMP_W-1:0]  pow_gap;
   logic [CMP_W-1:0]  pos_m1;
   logic              pos_ok;
   logic [ADDR_W-1:0] rd_msg_idx;
   logic [ADDR_W-1:0] rd_pow_idx;
   logic              msg_we;
   logic [ADDR_W-1:0] msg_waddr;
   logic [BYTE_W-1:0] msg_wdata;
   logic [REM_W-1:0]  patch_delta;

   // output slot is taken and not being drained this cycle
   assign out_blocked  = rsp_valid_ff & rsp_stall;
   assign req_stall    = (state_ff != ST_IDLE) | out_blocked;
   assign req_accept   = req_valid & ~req_stall;
   assign load_accept  = req_accept & ~req_mode;
   assign patch_accept = req_accept & req_mode;
   assign patch_fire   = (state_ff == ST_PATCH) & ~out_blocked;

   // load path: first clears before the byte, a full buffer drops the byte
   assign eff_len = req_first ? '0 : len_ff;
   assign eff_rem = req_first ? '0 : rem_ff;
   assign room    = eff_len < LEN_W'(MAX_LEN);

   // patch range check against the loaded length
   assign pos_ext    = CMP_W'(req_position);
   assign len_ext    = CMP_W'(len_ff);
   assign pow_gap    = len_ext - pos_ext;
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign pos_ok     = (req_position != '0) && (pos_ext <= len_ext);
   assign rd_msg_idx = pos_m1[ADDR_W-1:0];
   assign rd_pow_idx = pow_gap[ADDR_W-1:0];

   // (old xor new) * x^(8*(len-pos)) mod p
   assign patch_delta = crbp_reduce(crbp_clmul(msg_rd_ff ^ pat_byte_ff, pow_rd_ff));

   // one write port on the message memory, load and patch never overlap
   always_comb begin
      msg_we    = 1'b0;
      msg_waddr = eff_len[ADDR_W-1:0];
      msg_wdata = req_byte_value;
      if (load_accept && room) begin
         msg_we = 1'b1;
      end else if (patch_fire && !pat_err_ff) begin
         msg_we    = 1'b1;
         msg_waddr = pat_idx_ff;
         msg_wdata = pat_byte_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      fill_idx_in  = fill_idx_ff;
      fill_pow_in  = fill_pow_ff;
      pat_err_in   = pat_err_ff;
      pat_byte_in  = pat_byte_ff;
      pat_idx_in   = pat_idx_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_rem_in   = rsp_rem_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_FILL: begin
            fill_idx_in = fill_idx_ff + ADDR_W'(1);
            fill_pow_in = crbp_reduce({fill_pow_ff, BYTE_W'(0)});
            if (fill_idx_ff == ADDR_W'(MAX_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (load_accept) begin
               len_in = eff_len;
               rem_in = eff_rem;
               if (room) begin
                  len_in = eff_len + LEN_W'(1);
                  rem_in = crbp_reduce({eff_rem, req_byte_value});
               end
               if (req_last) begin
                  rsp_valid_in = 1'b1;
                  rsp_rem_in   = rem_in;
                  rsp_err_in   = 1'b0;
               end
            end else if (patch_accept) begin
               state_in    = ST_PATCH;
               pat_err_in  = ~pos_ok;
               pat_byte_in = req_byte_value;
               pat_idx_in  = rd_msg_idx;
            end
         end
         ST_PATCH: begin
            if (patch_fire) begin
               state_in = ST_IDLE;
               if (!pat_err_ff) begin
                  rem_in = rem_ff ^ patch_delta;
               end
               rsp_valid_in = 1'b1;
               rsp_rem_in   = rem_in;
               rsp_err_in   = pat_err_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         len_ff       <= '0;
         rem_ff       <= '0;
         fill_idx_ff  <= '0;
         fill_pow_ff  <= REM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         fill_idx_ff  <= fill_idx_in;
         fill_pow_ff  <= fill_pow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_err_ff  <= pat_err_in;
      pat_byte_ff <= pat_byte_in;
      pat_idx_ff  <= pat_idx_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // message memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[msg_waddr] <= msg_wdata;
      end
      if (patch_accept) begin
         msg_rd_ff <= msg_mem[rd_msg_idx];
      end
   end

   // power memory: written by the fill pass, registered read on patch
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         pow_mem[fill_idx_ff] <= fill_pow_ff;
      end
      if (patch_accept) begin
         pow_rd_ff <= pow_mem[rd_pow_idx];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_remainder      = rsp_rem_ff;
   assign rsp_position_error = rsp_err_ff;

   `CRBP_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(MAX_LEN),
      "message length beyond buffer size")
   `CRBP_ASSERT_NEXT(a_patch_enters_stage, clock, reset, patch_accept,
      state_ff == ST_PATCH, "accepted patch word did not enter patch stage")
   `CRBP_ASSERT_NEXT(a_first_load_len, clock, reset, load_accept && req_first,
      len_ff == LEN_W'(1), "first load word did not restart the length")
   `CRBP_ASSERT_NEXT(a_err_keeps_rem, clock, reset, patch_fire && pat_err_ff,
      rem_ff == $past(rem_ff) && rsp_valid_ff && rsp_err_ff,
      "out of range patch changed the remainder")

endmodule

[verif/testbench.sv]
// self-checking testbench for the crc32 remainder byte patch unit
module testbench;
   import crbp_pkg::*;

   localparam int unsigned LEN_MAX      = MAX_LEN_DEFAULT;
   localparam int unsigned RANDOM_WORDS = 380;
   // idle cycles allowed: covers the power memory fill after reset plus long stalls
   localparam int unsigned IDLE_LIMIT   = 40000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PATCH = 1'b1;

   // phases of idling: sender light / receiver heavy, swapped, then none
   localparam int unsigned PH_RX_HEAVY = 0;
   localparam int unsigned PH_TX_HEAVY = 1;
   localparam int unsigned PH_NO_IDLE  = 2;

   typedef struct {
      logic                mode;
      logic [BYTE_W-1:0]   byte_value;
      logic [POS_W-1:0]    position;
      logic                first;
      logic                last;
      int unsigned         phase;
   } patch_word_type;

   typedef struct {
      logic [REM_W-1:0] remainder;
      logic             position_error;
   } crc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = MODE_LOAD;
   logic [BYTE_W-1:0]   req_byte_value = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                req_first = 1'b0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [REM_W-1:0]    rsp_remainder;
   logic                rsp_position_error;

   // words waiting to be driven and results waiting to be seen
   patch_word_type      pending_words[$];
   crc_result_type      expected_results[$];

   // shadow of the block state
   logic [BYTE_W-1:0]   shadow_msg[LEN_MAX];
   logic [REM_W-1:0]    shadow_rem;
   int unsigned         shadow_len;
   logic [REM_W-1:0]    x8k_powers[LEN_MAX];

   int unsigned         error_count = 0;
   int unsigned         words_accepted = 0;
   int unsigned         total_words = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         cur_phase = PH_RX_HEAVY;
   int unsigned         gen_len = 0;
   int unsigned         gen_phase = PH_RX_HEAVY;

   crc32_remainder_byte_patch_unit #(
      .MAX_LEN(LEN_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_byte_value(req_byte_value),
      .req_position(req_position),
      .req_first(req_first),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_remainder(rsp_remainder),
      .rsp_position_error(rsp_position_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // reduce a degree < 40 polynomial modulo the crc polynomial, top bit down
   function automatic logic [REM_W-1:0] mod_poly40(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] acc;
      acc = v;
      for (int b = WIDE_W - 1; b >= REM_W; b--) begin
         if (acc[b]) begin
            acc ^= WIDE_W'(CRC_POLY) << (b - REM_W);
         end
      end
      return acc[REM_W-1:0];
   endfunction

   // byte difference times a stored power of x, modulo the polynomial
   function automatic logic [REM_W-1:0] scale_delta(input logic [BYTE_W-1:0] delta,
                                                    input logic [REM_W-1:0]  pw);
      logic [WIDE_W-1:0] prod;
      prod = '0;
      for (int b = 0; b < BYTE_W; b++) begin
         if (delta[b]) begin
            prod ^= {{BYTE_W{1'b0}}, pw} << b;
         end
      end
      return mod_poly40(prod);
   endfunction

   task automatic report_mismatch(input string what, input logic [REM_W-1:0] got,
                                  input logic [REM_W-1:0] want);
      $display("mismatch %s: got %h want %h after %0d words", what, got, want,
               words_accepted);
      error_count++;
   endtask

   // apply one accepted word to the shadow state, queue its result if any
   task automatic predict_crc(input logic mode, input logic [BYTE_W-1:0] value,
                              input logic [POS_W-1:0] pos, input logic first,
                              input logic last);
      crc_result_type res;
      int unsigned idx;
      res.position_error = 1'b0;
      if (mode == MODE_LOAD) begin
         if (first) begin
            shadow_rem = '0;
            shadow_len = 0;
         end
         // a byte beyond the buffer is dropped, flags still act
         if (shadow_len < LEN_MAX) begin
            shadow_msg[shadow_len] = value;
            shadow_len++;
            shadow_rem = mod_poly40({shadow_rem, value});
         end
         if (last) begin
            res.remainder = shadow_rem;
            expected_results.insert(expected_results.size(), res);
         end
      end else begin
         if (pos == 0 || pos > shadow_len) begin
            res.position_error = 1'b1;
         end else begin
            idx = pos - 1;
            shadow_rem ^= scale_delta(shadow_msg[idx] ^ value, x8k_powers[shadow_len - pos]);
            shadow_msg[idx] = value;
         end
         res.remainder = shadow_rem;
         expected_results.insert(expected_results.size(), res);
      end
   endtask

   // queue a word and track the length the block will see
   task automatic queue_word(input logic mode, input logic [BYTE_W-1:0] value,
                             input logic [POS_W-1:0] pos, input logic first,
                             input logic last);
      patch_word_type w;
      w.mode = mode;
      w.byte_value = value;
      w.position = pos;
      w.first = first;
      w.last = last;
      w.phase = gen_phase;
      pending_words.insert(pending_words.size(), w);
      total_words++;
      if (mode == MODE_LOAD) begin
         if (first) begin
            gen_len = 0;
         end
         if (gen_len < LEN_MAX) begin
            gen_len++;
         end
      end
   endtask

   // pick a patch position: mostly inside the message, sometimes zero or beyond it
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 7 && gen_len > 0) begin
         return POS_W'($urandom_range(1, gen_len));
      end else if (r == 7) begin
         return '0;
      end else if (r == 8 && gen_len + 1 < (1 << POS_W)) begin
         return POS_W'(gen_len + 1);
      end
      return POS_W'($urandom_range((1 << POS_W) - 1));
   endfunction

   // driver: a new word goes out once the previous one has been taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_words.size() != 0 &&
             !(cur_phase == PH_RX_HEAVY && $urandom_range(99) < 36) &&
             !(cur_phase == PH_TX_HEAVY && $urandom_range(99) < 81)) begin
            req_valid      <= 1'b1;
            req_mode       <= pending_words[0].mode;
            req_byte_value <= pending_words[0].byte_value;
            req_position   <= pending_words[0].position;
            req_first      <= pending_words[0].first;
            req_last       <= pending_words[0].last;
            cur_phase      <= pending_words[0].phase;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver backpressure follows the phase of the word last driven
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (cur_phase)
            PH_RX_HEAVY: begin
               rsp_stall <= ($urandom_range(99) < 81);
            end
            PH_TX_HEAVY: begin
               rsp_stall <= ($urandom_range(99) < 36);
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // monitor: check the result first, then predict the word taken at this edge
   always @(posedge clock) begin : monitor_blk
      crc_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with none expected", rsp_remainder, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_remainder !== want.remainder) begin
                  report_mismatch("remainder", rsp_remainder, want.remainder);
               end
               if (rsp_position_error !== want.position_error) begin
                  report_mismatch("position_error", REM_W'(rsp_position_error),
                                  REM_W'(want.position_error));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_crc(req_mode, req_byte_value, req_position, req_first, req_last);
            words_accepted++;
         end
      end
   end

   // watchdog on cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus_blk
      logic [REM_W-1:0] p;
      int unsigned      msg_bytes;
      int unsigned      kind;
      int unsigned      rand_words;
      bit               with_last;

      // power table x^(8k) mod p, and the state after reset
      p = 1;
      for (int k = 0; k < LEN_MAX; k++) begin
         x8k_powers[k] = p;
         p = mod_poly40({p, {BYTE_W{1'b0}}});
      end
      shadow_rem = '0;
      shadow_len = 0;

      // directed words
      queue_word(MODE_PATCH, 8'h5A, 13'd1, 1'b0, 1'b0);      // patch on empty message
      queue_word(MODE_LOAD, 8'hFF, 13'h1FFF, 1'b1, 1'b1);    // one byte message
      queue_word(MODE_LOAD, 8'h00, 13'h0000, 1'b1, 1'b0);    // four byte message
      queue_word(MODE_LOAD, 8'h80, 13'h1555, 1'b0, 1'b0);
      queue_word(MODE_LOAD, 8'h01, 13'h0AAA, 1'b0, 1'b0);
      queue_word(MODE_LOAD, 8'hA5, 13'h1FFF, 1'b0, 1'b1);
      queue_word(MODE_PATCH, 8'h00, 13'd1, 1'b0, 1'b0);      // first byte, highest power
      queue_word(MODE_PATCH, 8'hFF, 13'd4, 1'b0, 1'b0);      // last byte, power one
      queue_word(MODE_PATCH, 8'h80, 13'd2, 1'b1, 1'b1);      // same byte, flags ignored
      queue_word(MODE_PATCH, 8'h12, 13'd0, 1'b0, 1'b0);      // position zero
      queue_word(MODE_PATCH, 8'h34, 13'd5, 1'b0, 1'b0);      // just beyond the length
      queue_word(MODE_PATCH, 8'hFF, 13'h1FFF, 1'b1, 1'b0);   // largest position field
      queue_word(MODE_LOAD, 8'h3C, 13'd0, 1'b0, 1'b0);       // appends after a last
      queue_word(MODE_LOAD, 8'hC3, 13'd0, 1'b0, 1'b1);
      queue_word(MODE_PATCH, 8'h7E, 13'd6, 1'b0, 1'b0);
      queue_word(MODE_PATCH, 8'h01, 13'd3, 1'b0, 1'b1);
      queue_word(MODE_LOAD, 8'h00, 13'd0, 1'b1, 1'b1);       // all zero message
      queue_word(MODE_PATCH, 8'hFF, 13'd1, 1'b0, 1'b0);

      // random part, split over the three idling phases
      rand_words = 0;
      while (rand_words < RANDOM_WORDS) begin
         gen_phase = (rand_words * 3) / RANDOM_WORDS;
         kind = $urandom_range(9);
         if (kind <= 5) begin
            // well formed message, sometimes without a closing last
            msg_bytes = ($urandom_range(7) == 0) ? $urandom_range(1, 200)
                                                 : $urandom_range(1, 24);
            with_last = ($urandom_range(5) != 0);
            for (int i = 0; i < msg_bytes; i++) begin
               queue_word(MODE_LOAD, BYTE_W'($urandom_range(255)),
                          POS_W'($urandom_range(8191)), i == 0,
                          with_last && (i == msg_bytes - 1));
            end
            rand_words += msg_bytes;
         end else if (kind <= 8) begin
            // a burst of patches with random stray flags
            msg_bytes = $urandom_range(1, 4);
            for (int i = 0; i < msg_bytes; i++) begin
               queue_word(MODE_PATCH, BYTE_W'($urandom_range(255)), pick_position(),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            rand_words += msg_bytes;
         end else begin
            // noise load with random flags
            queue_word(MODE_LOAD, BYTE_W'($urandom_range(255)), POS_W'($urandom_range(8191)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            rand_words++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for all words taken, all results seen, then let the pipe drain
      while (words_accepted < total_words) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
